// ----- hdl/cbw_pkg.sv -----
package cbw_pkg;

  // size limits and field widths
  localparam int MAX_DIM    = 4096;
  localparam int PIXEL_BITS = 32;
  localparam int REG_BITS   = 13;
  localparam int COUNT_BITS = 12;
  localparam int POS_BITS   = 14;
  localparam int ADDR_BITS  = 24;
  localparam int INDEX_BITS = 3;

  typedef logic [REG_BITS-1:0]   reg_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [POS_BITS-1:0]   pos_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [INDEX_BITS-1:0] index_t;

  // register indexes
  localparam index_t REG_DEST_X     = 3'd0;
  localparam index_t REG_DEST_Y     = 3'd1;
  localparam index_t REG_SRC_WIDTH  = 3'd2;
  localparam index_t REG_SRC_HEIGHT = 3'd3;
  localparam index_t REG_FB_WIDTH   = 3'd4;
  localparam index_t REG_FB_HEIGHT  = 3'd5;

  localparam reg_t SIZE_MIN = reg_t'(1);
  localparam reg_t SIZE_MAX = reg_t'(MAX_DIM);

  // a size of zero acts as one, anything above the limit as the limit
  function automatic reg_t clamp_size(input reg_t v);
    reg_t r;
    if (v == '0) begin
      r = SIZE_MIN;
    end else if (v > SIZE_MAX) begin
      r = SIZE_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- hdl/clipped_blit_writer.sv -----
// clipped_blit_writer
// Streams the pixels of a source image, in row-major order, into framebuffer
// writes. Input channel: pixel with in_valid/in_ready. Output channel:
// write_address and write_data with out_valid/out_ready. Each accepted pixel
// gives one write if its position (dest_x + column, dest_y + row) lies inside
// the framebuffer, and no transaction otherwise.
// Configuration: cfg_write_enable, cfg_index and cfg_data write one register
// per cycle (0 dest_x, 1 dest_y, 2 src_width, 3 src_height, 4 fb_width,
// 5 fb_height); other indexes are ignored. Write only while the block is idle.
// Path: an accepted pixel enters the input register, then its write the
// result register. Throughput: one pixel per cycle unless out_ready stalls;
// each register takes a new transaction every cycle when not held.
// Reset: the column and row counters go to zero, dest_x and dest_y to zero,
// all sizes to one, and both pipeline stages are emptied.
// Stall: while out_ready is low the result register holds its transaction;
// the input register still drops outside pixels and fills once, after which
// in_ready falls until the output moves again.
module clipped_blit_writer
  import cbw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_enable,
  input  logic [INDEX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIXEL_BITS-1:0] pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ADDR_BITS-1:0]  write_address,
  output logic [PIXEL_BITS-1:0] write_data
);

  reg_t   dest_x;
  reg_t   dest_y;
  reg_t   src_width;
  reg_t   src_height;
  reg_t   fb_width;
  reg_t   fb_height;

  count_t src_column;
  count_t src_row;
  count_t src_column_next;
  count_t src_row_next;

  logic                  s1_valid;
  pos_t                  s1_fx;
  pos_t                  s1_fy;
  logic [PIXEL_BITS-1:0] s1_pixel;

  logic      in_accept;
  logic      s2_free;
  logic      s1_in_range;
  logic      s1_leave;
  logic      s2_load;
  pos_t      fx_next;
  pos_t      fy_next;
  addr_t     addr_full;

  // configuration registers, sizes clamped as they are written
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_x     <= '0;
      dest_y     <= '0;
      src_width  <= SIZE_MIN;
      src_height <= SIZE_MIN;
      fb_width   <= SIZE_MIN;
      fb_height  <= SIZE_MIN;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_DEST_X:     dest_x     <= cfg_data;
        REG_DEST_Y:     dest_y     <= cfg_data;
        REG_SRC_WIDTH:  src_width  <= clamp_size(cfg_data);
        REG_SRC_HEIGHT: src_height <= clamp_size(cfg_data);
        REG_FB_WIDTH:   fb_width   <= clamp_size(cfg_data);
        REG_FB_HEIGHT:  fb_height  <= clamp_size(cfg_data);
        default: ;
      endcase
    end
  end

  // handshake between the stages
  assign s2_free     = !out_valid || out_ready;
  assign s1_leave    = s1_valid && (!s1_in_range || s2_free);
  assign s2_load     = s1_valid && s1_in_range && s2_free;
  assign in_ready    = !s1_valid || s1_leave;
  assign in_accept   = in_valid && in_ready;

  // source position counters, wrapping at the image size
  always_comb begin
    src_column_next = src_column;
    src_row_next    = src_row;
    if (({1'b0, src_column} + reg_t'(1)) >= src_width) begin
      src_column_next = '0;
      if (({1'b0, src_row} + reg_t'(1)) >= src_height) begin
        src_row_next = '0;
      end else begin
        src_row_next = src_row + count_t'(1);
      end
    end else begin
      src_column_next = src_column + count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_column <= '0;
      src_row    <= '0;
    end else if (in_accept) begin
      src_column <= src_column_next;
      src_row    <= src_row_next;
    end
  end

  // framebuffer position, sign extended placement plus counter
  assign fx_next = {dest_x[REG_BITS-1], dest_x} + {2'b00, src_column};
  assign fy_next = {dest_y[REG_BITS-1], dest_y} + {2'b00, src_row};

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_fx    <= fx_next;
      s1_fy    <= fy_next;
      s1_pixel <= pixel;
    end
  end

  // per-pixel clip: non-negative and below the framebuffer size
  assign s1_in_range = !s1_fx[POS_BITS-1] && (s1_fx[REG_BITS-1:0] < fb_width) &&
                       !s1_fy[POS_BITS-1] && (s1_fy[REG_BITS-1:0] < fb_height);

  // row times stride plus column; in range the row fits in the counter width
  assign addr_full = addr_t'(s1_fy[COUNT_BITS-1:0]) * addr_t'(fb_width) +
                     addr_t'(s1_fx[REG_BITS-1:0]);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_free) begin
      out_valid <= s2_load;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      write_address <= addr_full;
      write_data    <= s1_pixel;
    end
  end

  // checks
  a_reset_counters: assert property (@(posedge clk)
    rst |=> (src_column == '0) && (src_row == '0))
    else $error("counters not cleared by reset");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input blocked with an empty input register");

  a_inside_reaches_output: assert property (@(posedge clk) disable iff (rst)
    s2_load |=> out_valid)
    else $error("clipped-in pixel lost between stages");

  a_address_in_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((ADDR_BITS+2)'(write_address) <
                   (ADDR_BITS+2)'(fb_width) * (ADDR_BITS+2)'(fb_height)))
    else $error("write address beyond the framebuffer");

endmodule
